@@ rtl/first_fit_heap_allocator_macros.svh @@
// Assertion macros shared by the first-fit heap allocator RTL.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define FFHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ffha_pkg.sv @@
// Package with the codes, widths and state type of the heap allocator.
`default_nettype none
package ffha_pkg;

  localparam int unsigned REQ_W        = 13;
  localparam int unsigned OFF_IN_W     = 12;
  localparam int unsigned OFF_OUT_W    = 12;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned MIN_SPLIT    = 4;

  // Request actions.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFIT    = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADFREE  = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_MARK,
    ST_MSTART,
    ST_MCUR,
    ST_MNXT,
    ST_RESP
  } state_e;

endpackage
`default_nettype wire

@@ rtl/ffha_if.sv @@
// Request and response channel interfaces of the heap allocator.
`default_nettype none
interface ffha_req_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [ffha_pkg::REQ_W-1:0] request_size;
  logic [ffha_pkg::OFF_IN_W-1:0] free_offset;

  modport source (output valid, action, request_size, free_offset, input ready);
  modport sink   (input valid, action, request_size, free_offset, output ready);
endinterface

interface ffha_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [ffha_pkg::STATUS_W-1:0]  status;
  logic [ffha_pkg::OFF_OUT_W-1:0] payload_offset;

  modport source (output valid, status, payload_offset, input ready);
  modport sink   (input valid, status, payload_offset, output ready);
endinterface
`default_nettype wire

@@ rtl/ffha_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output      logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// First-fit heap allocator over an implicit list of block headers.
//
// Requests arrive on req_i (valid/ready): action 0 allocates request_size bytes,
// action 1 frees the payload at free_offset. Each request gives one response on
// rsp_o (valid/ready) with a status and, for a good allocation, the payload offset.
// The block headers live in one RAM, one entry per 4-byte slot of the heap.
// An allocation reads the block headers one by one until a free block fits,
// and writes one more header when the chosen block is split. A free reads
// the headers up to and including the freed block. A good free then restarts
// at the heap start and walks the chain, merging each free block with the
// free blocks after it. A zero-size allocation is answered without a walk.
// Each header is read through the registered RAM read port; one request is
// worked on at a time.
// After reset the block writes the first header, then raises
// ready. A finished response sits in an output register; if the receiver
// stalls, the next request is still accepted and worked on, and its response
// waits until the register is free.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = 4096
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  ffha_req_if.sink  req_i,
  ffha_rsp_if.source rsp_o
);
  import ffha_pkg::*;

  `include "first_fit_heap_allocator_macros.svh"

  localparam int unsigned OffW  = $clog2(HEAP_BYTES);
  localparam int unsigned SizeW = (OffW > REQ_W) ? OffW : REQ_W;
  localparam int unsigned CmpW  = (OffW > OFF_IN_W) ? OffW : OFF_IN_W;
  localparam int unsigned Slots = HEAP_BYTES / 4;
  localparam int unsigned AddrW = $clog2(Slots);
  localparam int unsigned HdrW  = OffW + 1 + SizeW;
  localparam logic [OffW-1:0]  EndOff   = OffW'(((HEAP_BYTES - HEADER_BYTES) / 4) * 4);
  localparam logic [OffW-1:0]  HdrOff   = OffW'(HEADER_BYTES);
  localparam logic [SizeW-1:0] HdrSize  = SizeW'(HEADER_BYTES);
  localparam logic [SizeW-1:0] SplitMin = SizeW'(HEADER_BYTES + MIN_SPLIT);

  typedef struct packed {
    logic [OffW-1:0]  nxt;
    logic             alloc;
    logic [SizeW-1:0] size;
  } hdr_t;

  state_e state_q, state_d;
  logic                 act_q;
  logic [REQ_W-1:0]     req_q;
  logic [OFF_IN_W-1:0]  poff_q;
  logic [OffW-1:0]      cur_q, cur_d;
  logic [STATUS_W-1:0]  res_stat_q, res_stat_d;
  logic [OFF_OUT_W-1:0] res_off_q, res_off_d;
  logic                 rsp_valid_q;
  logic [STATUS_W-1:0]  rsp_stat_q;
  logic [OFF_OUT_W-1:0] rsp_off_q;

  logic             wr_en, rd_en;
  logic [AddrW-1:0] wr_addr, rd_addr;
  hdr_t             wr_hdr, rd_hdr;
  logic [HdrW-1:0]  rd_data;

  logic             accept, rsp_load;
  logic [REQ_W:0]   pad_sum;
  logic [SizeW:0]   padded;
  logic [OffW-1:0]  nx, cur_pay, noff;
  logic [SizeW-1:0] remain;
  logic             fits, split, match;

  ffha_ram #(.Width(HdrW), .Depth(Slots)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_hdr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_hdr = hdr_t'(rd_data);

  // Handshakes.
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == ST_RESP) && (!rsp_valid_q || rsp_o.ready);

  // Header decode and fit arithmetic for the header just read.
  assign pad_sum = {1'b0, req_q} + (REQ_W+1)'(3);
  assign padded  = (SizeW+1)'({pad_sum[REQ_W:2], 2'b00});
  assign nx      = {rd_hdr.nxt[OffW-1:1], 1'b0};
  assign cur_pay = cur_q + HdrOff;
  assign fits    = !rd_hdr.alloc && (padded <= {1'b0, rd_hdr.size});
  assign remain  = rd_hdr.size - padded[SizeW-1:0];
  assign split   = remain >= SplitMin;
  assign noff    = cur_pay + padded[OffW-1:0];
  assign match   = CmpW'(cur_pay) == CmpW'(poff_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req_i.action == ACT_ALLOC && req_i.request_size == '0) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (act_q == ACT_ALLOC) begin
          if (fits) begin
            state_d = split ? ST_MARK : ST_RESP;
          end else if (nx == EndOff) begin
            state_d = ST_RESP;
          end
        end else begin
          if (match) begin
            state_d = rd_hdr.alloc ? ST_MSTART : ST_RESP;
          end else if (nx == EndOff) begin
            state_d = ST_RESP;
          end
        end
      end
      ST_MARK:   state_d = ST_RESP;
      ST_MSTART: state_d = ST_MCUR;
      ST_MCUR: begin
        if (!rd_hdr.alloc && nx != EndOff) begin
          state_d = ST_MNXT;
        end else if (nx == EndOff) begin
          state_d = ST_RESP;
        end
      end
      ST_MNXT: begin
        if (nx == EndOff) begin
          state_d = ST_RESP;
        end else if (rd_hdr.alloc) begin
          state_d = ST_MCUR;
        end
      end
      ST_RESP: begin
        if (rsp_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // RAM accesses, walk pointer and result.
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = cur_q[OffW-1:2];
    wr_hdr     = '0;
    rd_en      = 1'b0;
    rd_addr    = nx[OffW-1:2];
    cur_d      = cur_q;
    res_stat_d = res_stat_q;
    res_off_d  = res_off_q;
    case (state_q)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_hdr  = '{nxt: EndOff, alloc: 1'b0, size: SizeW'(EndOff) - HdrSize};
      end
      ST_IDLE: begin
        rd_en      = accept;
        rd_addr    = '0;
        cur_d      = '0;
        res_stat_d = (req_i.action == ACT_FREE) ? STAT_BADFREE : STAT_NOFIT;
        res_off_d  = '0;
      end
      ST_WALK: begin
        if (act_q == ACT_ALLOC) begin
          if (fits) begin
            wr_en      = 1'b1;
            res_stat_d = STAT_OK;
            res_off_d  = OFF_OUT_W'(cur_pay);
            if (split) begin
              wr_addr = noff[OffW-1:2];
              wr_hdr  = '{nxt: rd_hdr.nxt, alloc: 1'b0, size: remain - HdrSize};
            end else begin
              wr_hdr  = '{nxt: rd_hdr.nxt, alloc: 1'b1, size: SizeW'(req_q)};
            end
          end else begin
            cur_d = nx;
            rd_en = 1'b1;
          end
        end else begin
          if (match) begin
            if (rd_hdr.alloc) begin
              wr_en      = 1'b1;
              wr_hdr     = '{nxt: rd_hdr.nxt, alloc: 1'b0,
                             size: SizeW'(rd_hdr.nxt - cur_pay)};
              res_stat_d = STAT_OK;
            end
          end else begin
            cur_d = nx;
            rd_en = 1'b1;
          end
        end
      end
      ST_MARK: begin
        wr_en  = 1'b1;
        wr_hdr = '{nxt: noff, alloc: 1'b1, size: SizeW'(req_q)};
      end
      ST_MSTART: begin
        rd_en   = 1'b1;
        rd_addr = '0;
        cur_d   = '0;
      end
      ST_MCUR: begin
        // A free block with a successor: fetch it; otherwise step on.
        rd_en = 1'b1;
        if (rd_hdr.alloc || nx == EndOff) begin
          cur_d = nx;
        end
      end
      ST_MNXT: begin
        // If the successor is free, absorb it into the current block; otherwise step on.
        rd_en = 1'b1;
        if (!rd_hdr.alloc) begin
          wr_en  = 1'b1;
          wr_hdr = '{nxt: rd_hdr.nxt, alloc: 1'b0, size: SizeW'(rd_hdr.nxt - cur_pay)};
        end else begin
          cur_d = nx;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    res_stat_q <= res_stat_d;
    res_off_q  <= res_off_d;
    if (accept) begin
      act_q  <= req_i.action;
      req_q  <= req_i.request_size;
      poff_q <= req_i.free_offset;
    end
    if (rsp_load) begin
      rsp_stat_q <= res_stat_q;
      rsp_off_q  <= res_off_q;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_stat_q;
  assign rsp_o.payload_offset = rsp_off_q;

  // Checks on the walk and the response path.
  `FFHA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE,
                    "accepted request did not start work")
  `FFHA_ASSERT_IMP(a_no_end_write, wr_en && state_q != ST_INIT,
                   wr_addr != EndOff[OffW-1:2], "write to the end marker slot")
  `FFHA_ASSERT_IMP(a_cur_in_heap, state_q != ST_IDLE && state_q != ST_INIT && state_q != ST_RESP,
                   cur_q < EndOff, "walk pointer left the heap")
  `FFHA_ASSERT_IMP(a_fail_no_offset, rsp_valid_q && rsp_stat_q != STAT_OK,
                   rsp_off_q == '0, "failed response carries an offset")

endmodule
`default_nettype wire
